// ----- sv/dpoa_pkg.sv -----
// shared types, constants and the microcode table of the dust pulse occupancy averager
package dpoa_pkg;

	localparam int PC_W       = 4;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam int TICK_W     = 16;
	localparam int SLOT_VAL_W = 8;
	localparam int PM_SUM_W   = 11;
	localparam int TOTAL_MAX  = 2047;
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 16;

	localparam logic [CFG_ADDR_W-1:0] CFG_WARMUP = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_STUCK  = 2'd1;

	localparam logic [CFG_DATA_W-1:0] WARMUP_RST = 16'd30000;
	localparam logic [CFG_DATA_W-1:0] STUCK_RST  = 16'd10000;

	// program addresses
	localparam logic [PC_W-1:0] STEP_FETCH  = 4'd0;
	localparam logic [PC_W-1:0] STEP_CLOSE  = 4'd1;
	localparam logic [PC_W-1:0] STEP_ACC    = 4'd2;
	localparam logic [PC_W-1:0] STEP_CHECK  = 4'd3;
	localparam logic [PC_W-1:0] STEP_DIV    = 4'd4;
	localparam logic [PC_W-1:0] STEP_SCALE  = 4'd5;
	localparam logic [PC_W-1:0] STEP_STORE  = 4'd6;
	localparam logic [PC_W-1:0] STEP_SAMPLE = 4'd7;
	localparam logic [PC_W-1:0] STEP_EMIT   = 4'd8;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LATCH,
		OP_CLOSE,
		OP_ACC,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_SCALE,
		OP_STORE,
		OP_SAMPLE,
		OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_NO_BEAT,
		COND_OUT_BUSY,
		COND_SKIP_CLOSE,
		COND_K_MORE,
		COND_FULL,
		COND_DIV_MORE
	} cond_t;

	// hold: stay on this step; jump: go to target instead of the next step
	typedef struct packed {
		op_t              op;
		cond_t            hold;
		cond_t            jump;
		logic [PC_W-1:0]  target;
	} uword_t;

	typedef struct packed {
		op_t  op;
		logic fire;
	} ctrl_t;

	typedef struct packed {
		logic no_beat;
		logic out_busy;
		logic skip_close;
		logic k_more;
		logic full;
		logic div_more;
	} status_t;

	function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
		uword_t w;
		unique case (pc)
			STEP_FETCH:  w = '{OP_LATCH,    COND_NO_BEAT,  COND_NEVER,      STEP_FETCH};
			STEP_CLOSE:  w = '{OP_CLOSE,    COND_NEVER,    COND_SKIP_CLOSE, STEP_SAMPLE};
			STEP_ACC:    w = '{OP_ACC,      COND_NEVER,    COND_K_MORE,     STEP_ACC};
			STEP_CHECK:  w = '{OP_DIV_INIT, COND_NEVER,    COND_FULL,       STEP_STORE};
			STEP_DIV:    w = '{OP_DIV_STEP, COND_NEVER,    COND_DIV_MORE,   STEP_DIV};
			STEP_SCALE:  w = '{OP_SCALE,    COND_NEVER,    COND_NEVER,      STEP_FETCH};
			STEP_STORE:  w = '{OP_STORE,    COND_NEVER,    COND_NEVER,      STEP_FETCH};
			STEP_SAMPLE: w = '{OP_SAMPLE,   COND_NEVER,    COND_NEVER,      STEP_FETCH};
			STEP_EMIT:   w = '{OP_EMIT,     COND_OUT_BUSY, COND_ALWAYS,     STEP_FETCH};
			default:     w = '{OP_NOP,      COND_NEVER,    COND_ALWAYS,     STEP_FETCH};
		endcase
		return w;
	endfunction

	function automatic logic cond_eval(input cond_t c, input status_t st);
		logic r;
		unique case (c)
			COND_NEVER:      r = 1'b0;
			COND_ALWAYS:     r = 1'b1;
			COND_NO_BEAT:    r = st.no_beat;
			COND_OUT_BUSY:   r = st.out_busy;
			COND_SKIP_CLOSE: r = st.skip_close;
			COND_K_MORE:     r = st.k_more;
			COND_FULL:       r = st.full;
			COND_DIV_MORE:   r = st.div_more;
			default:         r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

// ----- sv/dpoa_useq.sv -----
// microcode sequencer: step counter, control word fetch and conditional jumps
module dpoa_useq (
	input  logic             clk,
	input  logic             arst_n,
	input  dpoa_pkg::status_t status,
	output dpoa_pkg::ctrl_t   ctrl
);
	import dpoa_pkg::*;

	logic [PC_W-1:0] pc_q;
	uword_t          uw;
	logic            hold;
	logic            take;

	always_comb begin
		uw   = ucode_rom(pc_q);
		hold = cond_eval(uw.hold, status);
		take = cond_eval(uw.jump, status);
		ctrl.op   = uw.op;
		ctrl.fire = !hold;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_FETCH;
		end else if (!hold) begin
			if (take) begin
				pc_q <= uw.target;
			end else begin
				pc_q <= pc_q + PC_W'(1);
			end
		end
	end

endmodule

// ----- sv/dpoa_dpath.sv -----
// datapath: sample counters, window ring, sum accumulator, radix-2 divider and result register
module dpoa_dpath #(
	parameter int RING_SLOTS = 5,
	parameter int WINDOW_CAP = 250
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dpoa_pkg::ctrl_t                     ctrl,
	output dpoa_pkg::status_t                   status,
	input  logic                                cfg_we,
	input  logic [dpoa_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [dpoa_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [dpoa_pkg::IN_DATA_W-1:0]      s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [dpoa_pkg::OUT_DATA_W-1:0]     m_tdata
);
	import dpoa_pkg::*;

	localparam int SLOT_W = (RING_SLOTS > 2) ? $clog2(RING_SLOTS) : 1;
	localparam int CNT_W  = $clog2(RING_SLOTS + 1);
	localparam int ACC_W  = SLOT_VAL_W + CNT_W;
	localparam int DCNT_W = $clog2(ACC_W + 1);

	// architectural state
	logic [CFG_DATA_W-1:0] warm_cfg_q, stuck_cfg_q;
	logic [TICK_W-1:0]     tick_q, warm_q, stuck_q;
	logic [SLOT_VAL_W-1:0] ring_q [RING_SLOTS];
	logic [SLOT_W-1:0]     slot_q;
	logic                  full_q;
	logic [PM_SUM_W-1:0]   total_q;
	logic                  off_q;
	logic                  m_tvalid_q;

	// per-item scratch
	logic                  pwr_q, pin_q, we_q;
	logic [CNT_W-1:0]      n_q, k_q;
	logic [ACC_W-1:0]      acc_q, quo_q;
	logic [CNT_W-1:0]      rem_q;
	logic [DCNT_W-1:0]     dcnt_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	logic [SLOT_W-1:0]     wr_idx;
	logic [SLOT_VAL_W-1:0] capped;
	logic [CNT_W-1:0]      limit;
	logic [CNT_W:0]        rem_sh;
	logic                  rem_ge;
	logic                  fault;
	logic                  do_close;

	always_comb begin
		wr_idx = (CNT_W'(slot_q) >= CNT_W'(RING_SLOTS)) ? '0 : slot_q;
		capped = (tick_q > TICK_W'(WINDOW_CAP)) ? SLOT_VAL_W'(WINDOW_CAP)
			: tick_q[SLOT_VAL_W-1:0];
		limit  = full_q ? CNT_W'(RING_SLOTS) : n_q;
		rem_sh = {rem_q, quo_q[ACC_W-1]};
		rem_ge = rem_sh >= {1'b0, n_q};
		fault  = stuck_q == '0;
		do_close = we_q && !pin_q && warm_q == '0;

		status.no_beat    = !s_tvalid;
		status.out_busy   = m_tvalid_q && !m_tready;
		status.skip_close = !do_close;
		status.k_more     = (k_q + CNT_W'(1)) < limit;
		status.full       = full_q;
		status.div_more   = dcnt_q > DCNT_W'(1);
	end

	assign s_tready = ctrl.op == OP_LATCH;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warm_cfg_q  <= WARMUP_RST;
			stuck_cfg_q <= STUCK_RST;
			tick_q      <= '0;
			warm_q      <= WARMUP_RST;
			stuck_q     <= STUCK_RST;
			for (int i = 0; i < RING_SLOTS; i++) begin
				ring_q[i] <= '0;
			end
			slot_q      <= '0;
			full_q      <= 1'b0;
			total_q     <= '0;
			off_q       <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_addr == CFG_WARMUP) begin
					warm_cfg_q <= cfg_wdata;
				end else if (cfg_addr == CFG_STUCK) begin
					stuck_cfg_q <= cfg_wdata;
				end
			end
			if (ctrl.fire && ctrl.op == OP_EMIT) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (ctrl.fire) begin
				unique case (ctrl.op)
					OP_CLOSE: begin
						if (we_q && pin_q) begin
							slot_q <= '0;
							full_q <= 1'b0;
						end else if (do_close) begin
							ring_q[wr_idx] <= capped;
							tick_q         <= '0;
						end
					end
					OP_SCALE: begin
						if (n_q == CNT_W'(RING_SLOTS)) begin
							full_q <= 1'b1;
						end
					end
					OP_STORE: begin
						total_q <= (16'(acc_q) > 16'(TOTAL_MAX)) ? PM_SUM_W'(TOTAL_MAX)
							: PM_SUM_W'(acc_q);
						slot_q  <= (n_q == CNT_W'(RING_SLOTS)) ? '0 : n_q[SLOT_W-1:0];
					end
					OP_SAMPLE: begin
						if (!pwr_q) begin
							// first powered-off sample reinitializes once
							if (!off_q) begin
								tick_q  <= '0;
								total_q <= '0;
								warm_q  <= warm_cfg_q;
								stuck_q <= stuck_cfg_q;
								for (int i = 0; i < RING_SLOTS; i++) begin
									ring_q[i] <= '0;
								end
								off_q <= 1'b1;
							end
						end else begin
							off_q <= 1'b0;
							if (warm_q != '0) begin
								warm_q <= warm_q - TICK_W'(1);
							end else if (pin_q) begin
								if (tick_q != '1) begin
									tick_q <= tick_q + TICK_W'(1);
								end
								if (stuck_q != '0) begin
									stuck_q <= stuck_q - TICK_W'(1);
								end
							end else begin
								stuck_q <= stuck_cfg_q;
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.fire) begin
			unique case (ctrl.op)
				OP_LATCH: begin
					pwr_q <= s_tdata[0];
					pin_q <= s_tdata[1];
					we_q  <= s_tdata[2];
				end
				OP_CLOSE: begin
					n_q   <= CNT_W'(wr_idx) + CNT_W'(1);
					k_q   <= '0;
					acc_q <= '0;
				end
				OP_ACC: begin
					acc_q <= acc_q + ACC_W'(ring_q[k_q[SLOT_W-1:0]]);
					k_q   <= k_q + CNT_W'(1);
				end
				OP_DIV_INIT: begin
					quo_q  <= acc_q;
					rem_q  <= '0;
					dcnt_q <= DCNT_W'(ACC_W);
				end
				OP_DIV_STEP: begin
					// one quotient bit per step, restoring
					rem_q  <= rem_ge ? CNT_W'(rem_sh - {1'b0, n_q}) : CNT_W'(rem_sh);
					quo_q  <= {quo_q[ACC_W-2:0], rem_ge};
					dcnt_q <= dcnt_q - DCNT_W'(1);
				end
				OP_SCALE: begin
					acc_q <= ACC_W'(quo_q * ACC_W'(RING_SLOTS));
				end
				OP_EMIT: begin
					m_tdata_q <= {4'b0, fault, fault ? PM_SUM_W'(0) : total_q};
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- sv/dust_pulse_occupancy_averager.sv -----
// top level of the dust pulse occupancy averager
// One input beat is one 1 ms sensor sample; every sample gives exactly one result beat with
// the moving RING_SLOTS-window low-occupancy sum and the stuck-low fault flag. A small
// microcode program steps a shared datapath, so a sample is taken only while the program sits
// at its fetch step. A sample that closes no window passes through the fetch, close, sample
// and emit steps. A window close with a full ring runs the fetch, close, slot sum, check, store,
// sample and emit steps (the slot sum adds one slot per cycle). While the ring fills, the average
// goes through a one-bit-per-cycle divider between the check and scale steps. A result waiting
// in the output register holds the program at its last step until it is taken.
module dust_pulse_occupancy_averager #(
	parameter int RING_SLOTS = 5,
	parameter int WINDOW_CAP = 250
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [dpoa_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [dpoa_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [dpoa_pkg::IN_DATA_W-1:0]      s_tdata,  // power_on, pin_low, window_end, pad
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [dpoa_pkg::OUT_DATA_W-1:0]     m_tdata   // pm_sum[10:0], sensor_fault, pad
);
	import dpoa_pkg::*;

	localparam int SUM_LIMIT = (WINDOW_CAP * RING_SLOTS > TOTAL_MAX) ? TOTAL_MAX
		: WINDOW_CAP * RING_SLOTS;

	ctrl_t   ctrl;
	status_t status;

	dpoa_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	dpoa_dpath #(
		.RING_SLOTS (RING_SLOTS),
		.WINDOW_CAP (WINDOW_CAP)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.status    (status),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// the program leaves the fetch step right after a sample beat
	a_leave_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken twice in a row");

	// a faulty sensor reports a zero sum
	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[PM_SUM_W] |-> m_tdata[PM_SUM_W-1:0] == '0)
		else $error("nonzero sum with fault");

	a_sum_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[PM_SUM_W-1:0] <= PM_SUM_W'(SUM_LIMIT))
		else $error("sum above window cap times slots");

	// a result is emitted only from the last program step
	a_emit_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(ctrl.op == OP_EMIT))
		else $error("result outside emit step");

endmodule

// ----- bench/dust_pulse_occupancy_averager_test.sv -----
// self-checking testbench for the dust pulse occupancy averager
`timescale 1ns / 1ps

module dust_pulse_occupancy_averager_test;
	import dpoa_pkg::*;

	localparam int RING_SLOTS      = 5;
	localparam int WINDOW_CAP      = 250;
	localparam int CYCLE_LIMIT     = 3_000_000;
	localparam int PRESSURE_CYCLES = 400;
	localparam int TAIL_CYCLES     = 40;
	localparam int MAX_LINES       = 40;
	localparam int RANDOM_PHASES   = 6;
	localparam int PHASE_ITEMS     = 270;
	localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_B = 2'd3;

	typedef struct packed {
		logic [PM_SUM_W-1:0] pm_sum;
		logic                fault;
	} occupancy_t;

	class occupancy_tracker;
		logic [CFG_DATA_W-1:0] warm_cfg;
		logic [CFG_DATA_W-1:0] stuck_cfg;
		logic [TICK_W-1:0]     tick_count;
		logic [TICK_W-1:0]     warmup_left;
		logic [TICK_W-1:0]     stuck_left;
		logic [SLOT_VAL_W-1:0] ring [RING_SLOTS];
		logic [2:0]            slot;
		logic [PM_SUM_W-1:0]   total;
		bit                    full;
		bit                    off_seen;
		occupancy_t            pending_sums [$];
		int                    fails;
		int                    results_seen;

		function new();
			warm_cfg     = WARMUP_RST;
			stuck_cfg    = STUCK_RST;
			slot         = '0;
			full         = 1'b0;
			off_seen     = 1'b0;
			fails        = 0;
			results_seen = 0;
			reload();
		endfunction

		function void reload();
			tick_count  = '0;
			total       = '0;
			warmup_left = warm_cfg;
			stuck_left  = stuck_cfg;
			foreach (ring[k]) ring[k] = '0;
		endfunction

		function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			if (idx == CFG_WARMUP)
				warm_cfg = val;
			else if (idx == CFG_STUCK)
				stuck_cfg = val;
		endfunction

		function void close_window(bit low);
			int sum;
			int n;
			sum = 0;
			// a low pin at the strobe restarts the ring fill without storing
			if (low) begin
				slot = '0;
				full = 1'b0;
				return;
			end
			if (warmup_left != 0)
				return;
			if (slot >= RING_SLOTS)
				slot = '0;
			ring[slot] = (tick_count > WINDOW_CAP) ? SLOT_VAL_W'(WINDOW_CAP)
				: SLOT_VAL_W'(tick_count);
			tick_count = '0;
			slot = slot + 3'd1;
			if (full) begin
				for (int k = 0; k < RING_SLOTS; k++) sum += ring[k];
			end else begin
				n = slot;
				for (int k = 0; k < n; k++) sum += ring[k];
				sum = (sum / n) * RING_SLOTS;
				if (slot == RING_SLOTS)
					full = 1'b1;
			end
			total = (sum > TOTAL_MAX) ? PM_SUM_W'(TOTAL_MAX) : PM_SUM_W'(sum);
			slot = 3'(slot % RING_SLOTS);
		endfunction

		function void take_sample(bit pwr, bit low);
			if (!pwr) begin
				if (!off_seen) begin
					reload();
					off_seen = 1'b1;
				end
				return;
			end
			off_seen = 1'b0;
			if (warmup_left != 0) begin
				warmup_left = warmup_left - 1'b1;
				return;
			end
			if (low) begin
				if (tick_count != '1)
					tick_count = tick_count + 1'b1;
				if (stuck_left != 0)
					stuck_left = stuck_left - 1'b1;
			end else begin
				stuck_left = stuck_cfg;
			end
		endfunction

		function void note_sample(bit pwr, bit low, bit wend);
			occupancy_t want;
			if (wend)
				close_window(low);
			take_sample(pwr, low);
			want.fault  = (stuck_left == 0);
			want.pm_sum = want.fault ? '0 : total;
			pending_sums.push_back(want);
		endfunction

		function int pending();
			return pending_sums.size();
		endfunction

		task report(string msg);
			if (fails < MAX_LINES)
				$display("mismatch at result %0d: %s", results_seen, msg);
			fails++;
		endtask

		task check_result(logic [OUT_DATA_W-1:0] beat);
			occupancy_t want;
			results_seen++;
			if (pending_sums.size() == 0) begin
				report($sformatf("unexpected beat %h", beat));
				return;
			end
			want = pending_sums.pop_front();
			if (beat[PM_SUM_W-1:0] !== want.pm_sum)
				report($sformatf("pm_sum %0d, want %0d", beat[PM_SUM_W-1:0], want.pm_sum));
			if (beat[PM_SUM_W] !== want.fault)
				report($sformatf("sensor_fault %b, want %b", beat[PM_SUM_W], want.fault));
		endtask
	endclass

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	occupancy_tracker sb = new();
	bit quiet        = 1'b0;
	bit hold_request = 1'b0;
	int cycles       = 0;

	dust_pulse_occupancy_averager u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("dust_pulse_occupancy_averager regression: fail");
			$finish;
		end
	end

	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task send_sample(bit pwr, bit low, bit wend);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'b0, wend, low, pwr};
		do @(posedge clk); while (!s_tready);
		sb.note_sample(pwr, low, wend);
	endtask

	task drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// new values only take hold at the power-off reload
	task program_regs(logic [CFG_DATA_W-1:0] warm, logic [CFG_DATA_W-1:0] stuck);
		drain();
		write_reg(CFG_WARMUP, warm);
		write_reg(CFG_STUCK, stuck);
		send_sample(1'b0, 1'b0, 1'b0);
	endtask

	// sink side: random stalls, plus one long hold-off on request
	initial begin
		int stall_left;
		int r;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid === 1'b1 && m_tready)
				sb.check_result(m_tdata);
			if (hold_request) begin
				hold_request = 1'b0;
				stall_left = PRESSURE_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (quiet) begin
				m_tready <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 65) begin
					m_tready <= 1'b1;
				end else if (r < 95) begin
					stall_left = $urandom_range(0, 3);
					m_tready <= 1'b0;
				end else begin
					stall_left = $urandom_range(15, 60);
					m_tready <= 1'b0;
				end
			end
		end
	end

	initial begin
		logic [CFG_DATA_W-1:0] warm_list  [RANDOM_PHASES];
		logic [CFG_DATA_W-1:0] stuck_list [RANDOM_PHASES];
		bit pwr, low, wend, level;
		logic [2:0] noise;
		int r;
		warm_list  = '{16'd0, 16'd5, 16'd17, 16'd2, 16'd0, 16'd40};
		stuck_list = '{16'd1, 16'd65535, 16'd8, 16'd30, 16'd12, 16'd20};
		level = 1'b0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// default warm-up: strobes are ignored, a low strobe still clears the fill
		send_sample(1'b1, 1'b0, 1'b0);
		send_sample(1'b1, 1'b1, 1'b1);
		send_sample(1'b1, 1'b0, 1'b1);

		program_regs(16'd0, 16'd3);
		send_sample(1'b0, 1'b0, 1'b0);
		send_sample(1'b0, 1'b1, 1'b1);
		send_sample(1'b0, 1'b0, 1'b1);
		repeat (4) send_sample(1'b1, 1'b1, 1'b0);
		send_sample(1'b1, 1'b0, 1'b1);
		send_sample(1'b1, 1'b1, 1'b0);
		send_sample(1'b1, 1'b1, 1'b0);
		send_sample(1'b1, 1'b0, 1'b1);
		send_sample(1'b1, 1'b0, 1'b0);
		send_sample(1'b1, 1'b1, 1'b1);
		send_sample(1'b1, 1'b0, 1'b1);

		// zero timeout keeps the fault up, spare indexes must change nothing
		program_regs(16'd0, 16'd0);
		send_sample(1'b1, 1'b0, 1'b0);
		send_sample(1'b1, 1'b1, 1'b0);
		send_sample(1'b1, 1'b0, 1'b1);
		drain();
		write_reg(CFG_SPARE_A, 16'($urandom));
		write_reg(CFG_SPARE_B, 16'($urandom));
		send_sample(1'b0, 1'b0, 1'b0);
		send_sample(1'b1, 1'b0, 1'b0);

		program_regs(16'd65535, 16'd65535);
		send_sample(1'b1, 1'b0, 1'b1);
		send_sample(1'b1, 1'b1, 1'b0);
		send_sample(1'b1, 1'b0, 1'b1);

		// a long low run takes the stuck timer down to the fault
		program_regs(16'd0, 16'd20);
		quiet = 1'b1;
		repeat (40) send_sample(1'b1, 1'b1, 1'b0);
		send_sample(1'b1, 1'b0, 1'b1);
		send_sample(1'b1, 1'b0, 1'b0);
		quiet = 1'b0;

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			program_regs(warm_list[p], stuck_list[p]);
			quiet = (p != 2) && ($urandom_range(0, 3) == 0);
			if (p == 2)
				hold_request = 1'b1;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				r = $urandom_range(0, 99);
				if (r < 10) begin
					noise = 3'($urandom_range(0, 7));
					{wend, low, pwr} = noise;
				end else begin
					pwr = ($urandom_range(0, 99) >= 3);
					if ($urandom_range(0, 5) == 0)
						level = ~level;
					low  = level;
					wend = ($urandom_range(0, 11) == 0);
					if (wend)
						low = ($urandom_range(0, 4) == 0);
				end
				send_sample(pwr, low, wend);
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d results never arrived", sb.pending()));
		if (sb.fails == 0)
			$display("dust_pulse_occupancy_averager regression: pass");
		else
			$display("dust_pulse_occupancy_averager regression: fail");
		$finish;
	end

endmodule

// ----- dust_pulse_occupancy_averager.f -----
sv/dpoa_pkg.sv
sv/dpoa_useq.sv
sv/dpoa_dpath.sv
sv/dust_pulse_occupancy_averager.sv
bench/dust_pulse_occupancy_averager_test.sv
